@@ rtl/efc_pkg.sv @@
// Types and constants shared by the Ethernet frame classifier modules.
package efc_pkg;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_RARP = 16'h8035;

    localparam logic [7:0] PROTO_ICMP = 8'h01;
    localparam logic [7:0] PROTO_IGMP = 8'h02;
    localparam logic [7:0] PROTO_TCP  = 8'h06;
    localparam logic [7:0] PROTO_UDP  = 8'h11;

    localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;
    localparam logic [15:0] ARP_OP_REQ    = 16'h0001;
    localparam logic [15:0] RARP_OP_REQ   = 16'h0003;
    localparam logic [7:0]  IHL_MASK      = 8'h0f;

    localparam logic [3:0] CLS_UNSUPPORTED = 4'd0;
    localparam logic [3:0] CLS_IP          = 4'd1;
    localparam logic [3:0] CLS_ICMP_REQ    = 4'd2;
    localparam logic [3:0] CLS_ICMP_RES    = 4'd3;
    localparam logic [3:0] CLS_TCP         = 4'd4;
    localparam logic [3:0] CLS_UDP         = 4'd5;
    localparam logic [3:0] CLS_ARP_REQ     = 4'd6;
    localparam logic [3:0] CLS_ARP_RES     = 4'd7;
    localparam logic [3:0] CLS_RARP_REQ    = 4'd8;
    localparam logic [3:0] CLS_RARP_RES    = 4'd9;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  frame_class;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_out_item;

    // Header fields gathered while a frame streams in.
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] ethertype;
        logic [3:0]  ihl;
        logic [7:0]  protocol;
        logic [15:0] arp_opcode;
        logic [7:0]  icmp_type;
        logic [31:0] ip_src;
        logic [31:0] ip_dst;
        logic [31:0] arp_src;
        logic [31:0] arp_dst;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
    } t_hdr;

endpackage

@@ rtl/efc_capture.sv @@
// Byte offset counter and header field capture registers.
module efc_capture #(
    parameter int MAX_FRAME = 2047
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output efc_pkg::t_hdr     o_hdr
);
    import efc_pkg::*;

    localparam int OFF_W = $clog2(MAX_FRAME + 1);
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_FRAME);

    logic [OFF_W-1:0] r_offset;
    logic [OFF_W-1:0] n_offset;
    logic [OFF_W-1:0] l4;
    logic [3:0]       ihl_now;
    logic             in_range;
    t_hdr             r_hdr;
    t_hdr             n_hdr;

    assign in_range = (r_offset < OFF_MAX);
    // The header length counts from the byte that carries it, so a length of zero
    // places the transport header on that very byte.
    assign ihl_now  = (r_offset == OFF_W'(14)) ? i_byte[3:0] : r_hdr.ihl;
    // The transport header starts right after the IPv4 header.
    assign l4       = OFF_W'(14) + {{(OFF_W-6){1'b0}}, ihl_now, 2'b00};
    assign n_offset = in_range ? r_offset + OFF_W'(1) : r_offset;

    always_comb begin
        n_hdr = r_hdr;
        if (in_range) begin
            if (r_offset <= OFF_W'(5)) begin
                n_hdr.dest_mac = {r_hdr.dest_mac[39:0], i_byte};
            end else if (r_offset <= OFF_W'(11)) begin
                n_hdr.source_mac = {r_hdr.source_mac[39:0], i_byte};
            end else if (r_offset <= OFF_W'(13)) begin
                n_hdr.ethertype = {r_hdr.ethertype[7:0], i_byte};
            end
            if (r_offset == OFF_W'(14)) begin
                n_hdr.ihl = 4'(i_byte & IHL_MASK);
            end
            if (r_offset == OFF_W'(20) || r_offset == OFF_W'(21)) begin
                n_hdr.arp_opcode = {r_hdr.arp_opcode[7:0], i_byte};
            end
            if (r_offset == OFF_W'(23)) begin
                n_hdr.protocol = i_byte;
            end
            if (r_offset >= OFF_W'(26) && r_offset <= OFF_W'(29)) begin
                n_hdr.ip_src = {r_hdr.ip_src[23:0], i_byte};
            end
            if (r_offset >= OFF_W'(30) && r_offset <= OFF_W'(33)) begin
                n_hdr.ip_dst = {r_hdr.ip_dst[23:0], i_byte};
            end
            if (r_offset >= OFF_W'(28) && r_offset <= OFF_W'(31)) begin
                n_hdr.arp_src = {r_hdr.arp_src[23:0], i_byte};
            end
            if (r_offset >= OFF_W'(38) && r_offset <= OFF_W'(41)) begin
                n_hdr.arp_dst = {r_hdr.arp_dst[23:0], i_byte};
            end
            if (r_offset == l4) begin
                n_hdr.icmp_type = i_byte;
            end
            if (r_offset == l4 || r_offset == l4 + OFF_W'(1)) begin
                n_hdr.l4_sport = {r_hdr.l4_sport[7:0], i_byte};
            end
            if (r_offset == l4 + OFF_W'(2) || r_offset == l4 + OFF_W'(3)) begin
                n_hdr.l4_dport = {r_hdr.l4_dport[7:0], i_byte};
            end
        end
    end

    // Everything clears after the final byte so the next frame starts fresh.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_hdr    <= '0;
        end else if (i_valid) begin
            if (i_last) begin
                r_offset <= '0;
                r_hdr    <= '0;
            end else begin
                r_offset <= n_offset;
                r_hdr    <= n_hdr;
            end
        end
    end

    assign o_hdr = n_hdr;

endmodule

@@ rtl/efc_classify.sv @@
// Class decode and result field selection from the captured header.
module efc_classify (
    input  efc_pkg::t_hdr      i_hdr,
    output efc_pkg::t_out_item o_item
);
    import efc_pkg::*;

    always_comb begin
        o_item             = '0;
        o_item.dest_mac    = i_hdr.dest_mac;
        o_item.source_mac  = i_hdr.source_mac;
        if (i_hdr.ethertype == ETYPE_IPV4) begin
            o_item.source_ip = i_hdr.ip_src;
            o_item.dest_ip   = i_hdr.ip_dst;
            case (i_hdr.protocol) inside
                PROTO_ICMP: begin
                    o_item.frame_class = (i_hdr.icmp_type == ICMP_ECHO_REQ) ?
                                         CLS_ICMP_REQ : CLS_ICMP_RES;
                end
                PROTO_IGMP: begin
                    o_item.frame_class = CLS_UNSUPPORTED;
                end
                PROTO_TCP, PROTO_UDP: begin
                    o_item.frame_class = (i_hdr.protocol == PROTO_TCP) ?
                                         CLS_TCP : CLS_UDP;
                    o_item.source_port = i_hdr.l4_sport;
                    o_item.dest_port   = i_hdr.l4_dport;
                end
                default: begin
                    o_item.frame_class = CLS_IP;
                end
            endcase
        end else if (i_hdr.ethertype == ETYPE_ARP) begin
            o_item.frame_class = (i_hdr.arp_opcode == ARP_OP_REQ) ?
                                 CLS_ARP_REQ : CLS_ARP_RES;
            o_item.source_ip   = i_hdr.arp_src;
            o_item.dest_ip     = i_hdr.arp_dst;
        end else if (i_hdr.ethertype == ETYPE_RARP) begin
            o_item.frame_class = (i_hdr.arp_opcode == RARP_OP_REQ) ?
                                 CLS_RARP_REQ : CLS_RARP_RES;
            o_item.source_ip   = i_hdr.arp_src;
            o_item.dest_ip     = i_hdr.arp_dst;
        end
    end

endmodule

@@ rtl/ethernet_frame_classifier.sv @@
// Top level of the Ethernet frame classifier: input register, capture, result register.
// Frames enter one byte per item with the final byte marked; one result item leaves per
// frame. It is valid from the edge at which its final byte leaves the input register.
// The block takes a byte every clock unless it stalls: each byte passes an input
// register, then a single capture/compare step that feeds the result register. Bytes
// stall only when a finished result is still waiting in the result register and another
// final byte arrives behind it. Bytes at positions MAX_FRAME and beyond are counted as
// absent, and missing bytes read as zero.
module ethernet_frame_classifier #(
    parameter int MAX_FRAME = 2047
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  efc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output efc_pkg::t_out_item o_out_item
);
    import efc_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      adv;
    logic      load_out;
    t_hdr      hdr;
    t_out_item cls_item;

    // A final byte may only move on once the result register has room.
    assign adv        = r_in_vld &&
                        !(r_in.last_byte && r_out_vld && !i_out_ready);
    assign load_out   = adv && r_in.last_byte;
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    efc_capture #(
        .MAX_FRAME (MAX_FRAME)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (adv),
        .i_byte  (r_in.frame_byte),
        .i_last  (r_in.last_byte),
        .o_hdr   (hdr)
    );

    efc_classify u_classify (
        .i_hdr  (hdr),
        .o_item (cls_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= cls_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Ethernet frame classifier: directed table and random frames.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import efc_pkg::*;

    localparam int FRAME_LIMIT    = 256;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 25;
    localparam int RANDOM_BYTES   = 700;
    localparam int MIN_FRAMES     = 20;
    localparam int QUIET_FRAMES   = 5;

    typedef enum int {
        FK_IPV4,
        FK_ARP,
        FK_OTHER,
        FK_NOISE
    } t_frame_kind;

    typedef struct packed {
        t_in_item  it;
        logic      lit;
        t_out_item res;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    ethernet_frame_classifier #(
        .MAX_FRAME(FRAME_LIMIT)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Header capture state of the predictor.
    int unsigned cap_pos;
    logic [47:0] cap_dmac, cap_smac;
    logic [15:0] cap_etype, cap_opcode, cap_sport, cap_dport;
    logic [3:0]  cap_ihl;
    logic [7:0]  cap_proto, cap_icmp;
    logic [31:0] cap_ip_src, cap_ip_dst, cap_arp_src, cap_arp_dst;

    t_out_item  expected_results[$];
    logic [7:0] frame_q[$];
    t_dir_row   dir_rows[DIR_ROWS];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         quiet = 1'b0;
    bit         hold_req = 1'b0;

    task automatic clear_capture();
        cap_pos     = 0;
        cap_dmac    = '0;
        cap_smac    = '0;
        cap_etype   = '0;
        cap_opcode  = '0;
        cap_sport   = '0;
        cap_dport   = '0;
        cap_ihl     = '0;
        cap_proto   = '0;
        cap_icmp    = '0;
        cap_ip_src  = '0;
        cap_ip_dst  = '0;
        cap_arp_src = '0;
        cap_arp_dst = '0;
    endtask

    task automatic classify_byte(input t_in_item it, output bit done, output t_out_item res);
        logic [7:0]  b;
        int unsigned l4;
        b    = it.frame_byte;
        done = 1'b0;
        res  = '0;
        if (cap_pos < FRAME_LIMIT) begin
            if (cap_pos <= 5) cap_dmac = {cap_dmac[39:0], b};
            else if (cap_pos <= 11) cap_smac = {cap_smac[39:0], b};
            else if (cap_pos <= 13) cap_etype = {cap_etype[7:0], b};
            if (cap_pos == 14) cap_ihl = 4'(b & IHL_MASK);
            if (cap_pos == 20 || cap_pos == 21) cap_opcode = {cap_opcode[7:0], b};
            if (cap_pos == 23) cap_proto = b;
            if (cap_pos >= 26 && cap_pos <= 29) cap_ip_src = {cap_ip_src[23:0], b};
            if (cap_pos >= 30 && cap_pos <= 33) cap_ip_dst = {cap_ip_dst[23:0], b};
            if (cap_pos >= 28 && cap_pos <= 31) cap_arp_src = {cap_arp_src[23:0], b};
            if (cap_pos >= 38 && cap_pos <= 41) cap_arp_dst = {cap_arp_dst[23:0], b};
            // The layer 4 offset uses the header length as updated by this very byte.
            l4 = 14 + 4 * cap_ihl;
            if (cap_pos == l4) cap_icmp = b;
            if (cap_pos == l4 || cap_pos == l4 + 1) cap_sport = {cap_sport[7:0], b};
            if (cap_pos == l4 + 2 || cap_pos == l4 + 3) cap_dport = {cap_dport[7:0], b};
            cap_pos++;
        end
        if (it.last_byte) begin
            res.frame_class = CLS_UNSUPPORTED;
            res.dest_mac    = cap_dmac;
            res.source_mac  = cap_smac;
            if (cap_etype == ETYPE_IPV4) begin
                res.source_ip = cap_ip_src;
                res.dest_ip   = cap_ip_dst;
                case (cap_proto) inside
                    PROTO_ICMP: begin
                        res.frame_class = (cap_icmp == ICMP_ECHO_REQ) ? CLS_ICMP_REQ
                                                                      : CLS_ICMP_RES;
                    end
                    PROTO_IGMP: res.frame_class = CLS_UNSUPPORTED;
                    PROTO_TCP, PROTO_UDP: begin
                        res.frame_class = (cap_proto == PROTO_TCP) ? CLS_TCP : CLS_UDP;
                        res.source_port = cap_sport;
                        res.dest_port   = cap_dport;
                    end
                    default: res.frame_class = CLS_IP;
                endcase
            end else if (cap_etype == ETYPE_ARP) begin
                res.frame_class = (cap_opcode == ARP_OP_REQ) ? CLS_ARP_REQ : CLS_ARP_RES;
                res.source_ip   = cap_arp_src;
                res.dest_ip     = cap_arp_dst;
            end else if (cap_etype == ETYPE_RARP) begin
                res.frame_class = (cap_opcode == RARP_OP_REQ) ? CLS_RARP_REQ : CLS_RARP_RES;
                res.source_ip   = cap_arp_src;
                res.dest_ip     = cap_arp_dst;
            end
            done = 1'b1;
            clear_capture();
        end
    endtask

    function automatic t_dir_row mk_row(logic [7:0] b, logic last, logic lit, t_out_item res);
        t_dir_row row;
        row.it.frame_byte = b;
        row.it.last_byte  = last;
        row.lit           = lit;
        row.res           = res;
        return row;
    endfunction

    task automatic send_item(input t_in_item it, input bit lit, input t_out_item lit_res);
        bit        done;
        t_out_item pred;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        classify_byte(it, done, pred);
        if (done) expected_results.push_back(lit ? lit_res : pred);
    endtask

    task automatic send_frame();
        t_in_item it;
        for (int i = 0; i < frame_q.size(); i++) begin
            it.frame_byte = frame_q[i];
            it.last_byte  = (i == frame_q.size() - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    // Mostly well-formed headers with random content; some noise and truncated frames.
    task automatic build_frame(input int long_len);
        t_frame_kind kind;
        int          len, ihl, l4, pick;
        logic [15:0] etype, op;
        logic [7:0]  proto;
        frame_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 40) kind = FK_IPV4;
        else if (pick < 70) kind = FK_ARP;
        else if (pick < 82) kind = FK_OTHER;
        else kind = FK_NOISE;
        if (long_len > 0) kind = FK_IPV4;
        ihl = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
        case (kind)
            FK_IPV4:  len = ((18 + 4 * ihl > 34) ? 18 + 4 * ihl : 34) + $urandom_range(0, 6);
            FK_ARP:   len = 42 + $urandom_range(0, 18);
            FK_OTHER: len = 14 + $urandom_range(0, 40);
            default:  len = $urandom_range(1, 48);
        endcase
        if (long_len > 0) len = long_len;
        for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom()));
        if (kind != FK_NOISE) begin
            pick = $urandom_range(0, 7);
            for (int i = 0; i < 6; i++) begin
                if (pick == 0) frame_q[i] = 8'hFF;
                else if (pick == 1) frame_q[i] = 8'h00;
            end
        end
        case (kind)
            FK_IPV4: begin
                frame_q[12] = ETYPE_IPV4[15:8];
                frame_q[13] = ETYPE_IPV4[7:0];
                frame_q[14] = {($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'h4, 4'(ihl)};
                case ($urandom_range(0, 5))
                    0, 5:    proto = PROTO_ICMP;
                    1:       proto = PROTO_IGMP;
                    2:       proto = PROTO_TCP;
                    3:       proto = PROTO_UDP;
                    default: proto = 8'($urandom());
                endcase
                frame_q[23] = proto;
                l4 = 14 + 4 * ihl;
                // With a header length of zero the type byte is the length byte itself.
                if (proto == PROTO_ICMP && l4 != 14 && l4 < len) begin
                    frame_q[l4] = ($urandom_range(0, 1) == 0) ? ICMP_ECHO_REQ
                                                              : 8'($urandom_range(0, 15));
                end
            end
            FK_ARP: begin
                etype = ($urandom_range(0, 1) == 0) ? ETYPE_ARP : ETYPE_RARP;
                case ($urandom_range(0, 4))
                    0:       op = ARP_OP_REQ;
                    1:       op = RARP_OP_REQ;
                    2:       op = 16'h0002;
                    3:       op = 16'h0004;
                    default: op = 16'($urandom());
                endcase
                frame_q[12] = etype[15:8];
                frame_q[13] = etype[7:0];
                frame_q[20] = op[15:8];
                frame_q[21] = op[7:0];
            end
            FK_OTHER: begin
                case ($urandom_range(0, 2))
                    0:       etype = 16'($urandom());
                    1:       etype = ETYPE_ARP ^ (16'h1 << $urandom_range(0, 15));
                    default: etype = ETYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15));
                endcase
                frame_q[12] = etype[15:8];
                frame_q[13] = etype[7:0];
            end
            default: ;
        endcase
        if (kind != FK_NOISE && long_len == 0 && $urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, len);
            while (frame_q.size() > len) void'(frame_q.pop_back());
        end
    endtask

    // Result side: random readiness, one long hold-off, and full speed at the end.
    initial begin
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (quiet) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else if (hold_req && !held) begin
                i_out_ready <= 1'b0;
                held = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                if ($urandom_range(0, 1) == 0) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) $display("unexpected result item: %p", o_out_item);
            end else begin
                t_out_item want;
                want = expected_results.pop_front();
                if (want.frame_class !== o_out_item.frame_class ||
                    want.dest_mac !== o_out_item.dest_mac ||
                    want.source_mac !== o_out_item.source_mac ||
                    want.source_ip !== o_out_item.source_ip ||
                    want.dest_ip !== o_out_item.dest_ip ||
                    want.source_port !== o_out_item.source_port ||
                    want.dest_port !== o_out_item.dest_port) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch (expected/actual): class %0d/%0d dmac %h/%h smac %h/%h",
                                 want.frame_class, o_out_item.frame_class, want.dest_mac,
                                 o_out_item.dest_mac, want.source_mac, o_out_item.source_mac);
                        $display("  sip %h/%h dip %h/%h sport %h/%h dport %h/%h",
                                 want.source_ip, o_out_item.source_ip, want.dest_ip,
                                 o_out_item.dest_ip, want.source_port, o_out_item.source_port,
                                 want.dest_port, o_out_item.dest_port);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[ethernet_frame_classifier] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int sent_bytes;
        int frames;
        dir_rows[0]  = mk_row(8'h00, 1'b1, 1'b1, '0);
        dir_rows[1]  = mk_row(8'hFF, 1'b1, 1'b1, t_out_item'{CLS_UNSUPPORTED, 48'hFF, 48'h0,
                                                            32'h0, 32'h0, 16'h0, 16'h0});
        dir_rows[2]  = mk_row(8'hFF, 1'b0, 1'b0, '0);
        dir_rows[3]  = mk_row(8'hFF, 1'b0, 1'b0, '0);
        dir_rows[4]  = mk_row(8'hFF, 1'b0, 1'b0, '0);
        dir_rows[5]  = mk_row(8'hFF, 1'b0, 1'b0, '0);
        dir_rows[6]  = mk_row(8'hFF, 1'b0, 1'b0, '0);
        dir_rows[7]  = mk_row(8'hFF, 1'b0, 1'b0, '0);
        dir_rows[8]  = mk_row(8'h00, 1'b0, 1'b0, '0);
        dir_rows[9]  = mk_row(8'h00, 1'b0, 1'b0, '0);
        dir_rows[10] = mk_row(8'h00, 1'b0, 1'b0, '0);
        dir_rows[11] = mk_row(8'h00, 1'b0, 1'b0, '0);
        dir_rows[12] = mk_row(8'h00, 1'b0, 1'b0, '0);
        dir_rows[13] = mk_row(8'h00, 1'b0, 1'b0, '0);
        dir_rows[14] = mk_row(8'h08, 1'b0, 1'b0, '0);
        // An ARP frame cut after its ethertype: the opcode never arrives and reads as zero.
        dir_rows[15] = mk_row(8'h06, 1'b1, 1'b1, t_out_item'{CLS_ARP_RES, 48'hFFFF_FFFF_FFFF,
                                                            48'h0, 32'h0, 32'h0, 16'h0, 16'h0});
        dir_rows[16] = mk_row(8'h12, 1'b0, 1'b0, '0);
        dir_rows[17] = mk_row(8'h34, 1'b1, 1'b1, t_out_item'{CLS_UNSUPPORTED, 48'h1234, 48'h0,
                                                            32'h0, 32'h0, 16'h0, 16'h0});
        dir_rows[18] = mk_row(8'hAA, 1'b0, 1'b0, '0);
        dir_rows[19] = mk_row(8'h55, 1'b0, 1'b0, '0);
        dir_rows[20] = mk_row(8'h01, 1'b0, 1'b0, '0);
        dir_rows[21] = mk_row(8'h80, 1'b0, 1'b0, '0);
        dir_rows[22] = mk_row(8'h7F, 1'b0, 1'b0, '0);
        dir_rows[23] = mk_row(8'hFE, 1'b0, 1'b0, '0);
        dir_rows[24] = mk_row(8'h3C, 1'b1, 1'b0, '0);

        clear_capture();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(dir_rows[r].it, dir_rows[r].lit, dir_rows[r].res);
        end
        // The last row ends a frame, so at least one result is still due here.
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);

        sent_bytes = 0;
        frames     = 0;
        while (sent_bytes < RANDOM_BYTES || frames < MIN_FRAMES) begin
            if (frames == 5) hold_req = 1'b1;
            if (frames == 10) begin
                build_frame(FRAME_LIMIT);
            end else if (frames == 15) begin
                build_frame(FRAME_LIMIT + $urandom_range(1, 100));
            end else begin
                build_frame(0);
                sent_bytes += frame_q.size();
            end
            send_frame();
            frames++;
        end

        quiet = 1'b1;
        repeat (QUIET_FRAMES) begin
            build_frame(0);
            send_frame();
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[ethernet_frame_classifier] OK");
        end else begin
            $display("[ethernet_frame_classifier] ERROR");
        end
        $finish;
    end

endmodule
